// ===== src/mlfq_pkg.sv =====
// Package with shared constants, types and codes for the MLFQ scheduler.
package mlfq_pkg;

	localparam int LEVELS_DEF   = 20;
	localparam int MAX_JOBS_DEF = 64;

	localparam int ID_W   = 6;
	localparam int LVL_W  = 5;
	localparam int TIME_W = 16;
	localparam int ALW_W  = 10;
	localparam int EV_W   = 3;
	localparam int SC_W   = 32;

	localparam logic [ALW_W-1:0]  ALLOT_RST = 10'd10;
	localparam logic [TIME_W-1:0] BOOST_RST = 16'd50;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic CFG_ALLOT = 1'b0;
	localparam logic CFG_BOOST = 1'b1;

	typedef enum logic [EV_W-1:0] {
		EV_LOADED    = 3'd0,
		EV_RAN       = 3'd1,
		EV_COMPLETED = 3'd2,
		EV_DOWNGRADE = 3'd3,
		EV_IDLE      = 3'd4,
		EV_FULL      = 3'd5
	} event_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_MOD,
		ST_WALK,
		ST_RUN,
		ST_UPD,
		ST_UNLINK,
		ST_APPEND,
		ST_CNT,
		ST_BDIV,
		ST_BST_LVL,
		ST_BST_JOB,
		ST_BST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic is_add;
		logic add_ok;
		logic lvl_found;
		logic scan_end;
		logic div_done;
		logic walk_done;
		logic boost_due;
		logic move;
		logic down;
		logic blvl_end;
		logic blvl_nonempty;
		logic bjob_end;
	} status_t;

	typedef struct packed {
		logic load_in;
		logic do_add;
		logic scan_init;
		logic scan_step;
		logic div_start;
		logic div_step;
		logic walk_step;
		logic run;
		logic upd;
		logic unlink;
		logic append;
		logic cnt;
		logic bdiv_start;
		logic blvl_init;
		logic blvl_take;
		logic blvl_next;
		logic bjob_step;
		logic bst_fin;
		logic set_idle;
		logic set_full;
	} cmd_t;

endpackage

// ===== src/mlfq_if.sv =====
// Valid/ready channel interfaces for the MLFQ scheduler.
interface mlfq_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] run_time;
	modport source (output valid, output op, output run_time, input ready);
	modport sink (input valid, input op, input run_time, output ready);
endinterface

interface mlfq_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [5:0]  job_id;
	logic [4:0]  level;
	logic [15:0] remaining;
	logic [15:0] time_in_level;
	logic        boosted;
	modport source (output valid, output event_res, output job_id, output level,
		output remaining, output time_in_level, output boosted, input ready);
	modport sink (input valid, input event_res, input job_id, input level,
		input remaining, input time_in_level, input boosted, output ready);
endinterface

interface mlfq_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/mlfq_ctrl.sv =====
// Controller state machine sequencing the MLFQ scheduler datapath.
module mlfq_ctrl
	import mlfq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (st.is_add) begin
					if (st.add_ok) begin
						cmd.do_add = 1'b1;
					end else begin
						cmd.set_full = 1'b1;
					end
					state_d = ST_OUT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.lvl_found) begin
					cmd.div_start = 1'b1;
					state_d = ST_MOD;
				end else if (st.scan_end) begin
					cmd.set_idle = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_MOD: begin
				if (st.div_done) begin
					state_d = ST_WALK;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_WALK: begin
				if (st.walk_done) begin
					state_d = ST_RUN;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_RUN: begin
				cmd.run = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = st.move ? ST_UNLINK : ST_CNT;
			end
			ST_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d = st.down ? ST_APPEND : ST_CNT;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d = ST_CNT;
			end
			ST_CNT: begin
				cmd.cnt = 1'b1;
				cmd.bdiv_start = 1'b1;
				state_d = ST_BDIV;
			end
			ST_BDIV: begin
				if (st.div_done) begin
					if (st.boost_due) begin
						cmd.blvl_init = 1'b1;
						state_d = ST_BST_LVL;
					end else begin
						state_d = ST_OUT;
					end
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_BST_LVL: begin
				if (st.blvl_end) begin
					cmd.bst_fin = 1'b1;
					state_d = ST_BST_FIN;
				end else if (st.blvl_nonempty) begin
					cmd.blvl_take = 1'b1;
					state_d = ST_BST_JOB;
				end else begin
					cmd.blvl_next = 1'b1;
				end
			end
			ST_BST_JOB: begin
				cmd.bjob_step = 1'b1;
				if (st.bjob_end) begin
					cmd.blvl_next = 1'b1;
					state_d = ST_BST_LVL;
				end
			end
			ST_BST_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/mlfq_dp.sv =====
// Datapath of the MLFQ scheduler: job table, level queues and divider.
module mlfq_dp
	import mlfq_pkg::*;
#(
	parameter int LEVELS   = LEVELS_DEF,
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_op,
	input  logic [TIME_W-1:0] in_run_time,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [TIME_W-1:0] cfg_data,
	input  cmd_t              cmd,
	output status_t           st,
	output logic [EV_W-1:0]   event_res,
	output logic [ID_W-1:0]   job_id,
	output logic [LVL_W-1:0]  level,
	output logic [TIME_W-1:0] remaining,
	output logic [TIME_W-1:0] time_in_level,
	output logic              boosted
);

	localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int LCW = $clog2(LEVELS + 1);

	// Job table memories, one access per cycle each.
	logic [TIME_W-1:0] rem_mem [MAX_JOBS];
	logic [TIME_W-1:0] til_mem [MAX_JOBS];
	logic [JW-1:0]     link_mem [MAX_JOBS];

	logic [JW-1:0] head_q [LEVELS];
	logic [JW-1:0] tail_q [LEVELS];
	logic [CW-1:0] cnt_q  [LEVELS];

	logic [ALW_W-1:0]  allot_q;
	logic [TIME_W-1:0] bper_q;
	logic [SC_W-1:0]   slice_q;
	logic [CW-1:0]     added_q;

	logic              op_q;
	logic [TIME_W-1:0] rt_q;
	logic [LCW-1:0]    lv_q;
	logic [LVL_W-1:0]  rlv_q;
	logic [JW-1:0]     cur_q, prev_q;
	logic [CW-1:0]     k_q;
	logic [JW-1:0]     next_q;
	logic [TIME_W-1:0] rem_q, til_q;
	logic              down_q;
	logic [EV_W-1:0]   ev_q;
	logic              bst_q;

	// Restoring divider for remainder only: slice count mod divisor.
	logic [SC_W-1:0]   dvd_q;
	logic [TIME_W:0]   rmd_q;
	logic [TIME_W-1:0] dvs_q;
	logic [5:0]        dcnt_q;
	logic [TIME_W+1:0] trial;

	// Boost walk state.
	logic              bany_q;
	logic [JW-1:0]     bhead_q, btail_q;
	logic [CW-1:0]     btotal_q, bk_q;
	logic [JW-1:0]     bj_q;

	logic [LW-1:0] lvi, lvn;
	logic [ALW_W+LVL_W:0] allot_lim;

	// Slice outcome, decided from the entry read in the run state.
	logic [TIME_W-1:0] rem_dec, til_inc;
	logic              done_w, down_w;

	assign lvi = lv_q[LW-1:0];
	assign lvn = LW'(lv_q + LCW'(1));
	assign trial = {rmd_q, dvd_q[SC_W-1]} - {2'b0, dvs_q};
	assign allot_lim = (ALW_W+LVL_W+1)'(lv_q + LCW'(1)) * (ALW_W+LVL_W+1)'(allot_q);

	assign rem_dec = (rem_q != '0) ? rem_q - TIME_W'(1) : rem_q;
	assign til_inc = (til_q != '1) ? til_q + TIME_W'(1) : til_q;
	assign done_w  = (rem_dec == '0);
	assign down_w  = !done_w && (lv_q + LCW'(1) < LCW'(LEVELS))
		&& ((ALW_W+LVL_W+1)'(til_inc) >= allot_lim);

	always_comb begin
		st = '0;
		st.is_add        = (op_q == OP_ADD);
		st.add_ok        = (added_q != CW'(MAX_JOBS));
		st.lvl_found     = (lv_q < LCW'(LEVELS)) && (cnt_q[lvi] != '0);
		st.scan_end      = (lv_q >= LCW'(LEVELS));
		st.div_done      = (dcnt_q == '0);
		st.walk_done     = (k_q == rmd_q[CW-1:0]);
		st.boost_due     = (bper_q != '0) && (rmd_q == '0);
		st.move          = done_w || down_w;
		st.down          = down_q;
		st.blvl_end      = (lv_q >= LCW'(LEVELS));
		st.blvl_nonempty = (lv_q < LCW'(LEVELS)) && (cnt_q[lvi] != '0);
		st.bjob_end      = (bk_q + CW'(1) >= cnt_q[lvi]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= in_op;
			rt_q <= in_run_time;
		end
		if (cmd.do_add) begin
			rem_mem[added_q[JW-1:0]] <= rt_q;
			til_mem[added_q[JW-1:0]] <= '0;
			if (cnt_q[0] != '0) begin
				link_mem[tail_q[0]] <= added_q[JW-1:0];
			end
		end
		if (cmd.scan_init || cmd.blvl_init) begin
			lv_q <= '0;
		end else if (cmd.scan_step || cmd.blvl_next) begin
			lv_q <= lv_q + LCW'(1);
		end
		if (cmd.div_start) begin
			cur_q  <= head_q[lvi];
			prev_q <= head_q[lvi];
			k_q    <= '0;
		end else if (cmd.walk_step) begin
			prev_q <= cur_q;
			cur_q  <= link_mem[cur_q];
			k_q    <= k_q + CW'(1);
		end else if (cmd.do_add) begin
			cur_q <= added_q[JW-1:0];
		end else if (cmd.set_full || cmd.set_idle) begin
			cur_q <= '0;
		end
		if (cmd.div_start || cmd.bdiv_start) begin
			dvd_q  <= cmd.bdiv_start ? slice_q + SC_W'(1) : slice_q;
			dvs_q  <= cmd.bdiv_start ? bper_q : TIME_W'(cnt_q[lvi]);
			rmd_q  <= '0;
			dcnt_q <= 6'(SC_W);
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[SC_W-2:0], 1'b0};
			dcnt_q <= dcnt_q - 6'd1;
			if (!trial[TIME_W+1]) begin
				rmd_q <= trial[TIME_W:0];
			end else begin
				rmd_q <= {rmd_q[TIME_W-1:0], dvd_q[SC_W-1]};
			end
		end
		if (cmd.run) begin
			rem_q  <= rem_mem[cur_q];
			til_q  <= til_mem[cur_q];
			next_q <= link_mem[cur_q];
		end else if (cmd.upd) begin
			rem_q <= rem_dec;
			til_q <= til_inc;
		end else if (cmd.do_add) begin
			rem_q <= rt_q;
			til_q <= '0;
		end else if (cmd.set_full || cmd.set_idle) begin
			rem_q <= '0;
			til_q <= '0;
		end
		if (cmd.upd) begin
			rem_mem[cur_q] <= rem_dec;
			til_mem[cur_q] <= down_w ? '0 : til_inc;
			down_q <= down_w;
			rlv_q  <= LVL_W'(lv_q);
			ev_q   <= done_w ? EV_COMPLETED : (down_w ? EV_DOWNGRADE : EV_RAN);
		end else if (cmd.do_add) begin
			ev_q  <= EV_LOADED;
			rlv_q <= '0;
		end else if (cmd.set_full) begin
			ev_q  <= EV_FULL;
			rlv_q <= '0;
		end else if (cmd.set_idle) begin
			ev_q  <= EV_IDLE;
			rlv_q <= '0;
		end
		if (cmd.blvl_init) begin
			bst_q <= 1'b1;
		end else if (cmd.run || cmd.do_add || cmd.set_full || cmd.set_idle) begin
			bst_q <= 1'b0;
		end
		if (cmd.unlink && k_q != '0) begin
			link_mem[prev_q] <= next_q;
		end
		if (cmd.append && cnt_q[lvn] != '0) begin
			link_mem[tail_q[lvn]] <= cur_q;
		end
		if (cmd.blvl_take) begin
			bj_q <= head_q[lvi];
			bk_q <= '0;
			if (bany_q) begin
				link_mem[btail_q] <= head_q[lvi];
			end
		end
		if (cmd.bjob_step) begin
			til_mem[bj_q] <= '0;
			bj_q <= link_mem[bj_q];
			bk_q <= bk_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allot_q  <= ALLOT_RST;
			bper_q   <= BOOST_RST;
			slice_q  <= '0;
			added_q  <= '0;
			bany_q   <= 1'b0;
			bhead_q  <= '0;
			btail_q  <= '0;
			btotal_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ALLOT) begin
					allot_q <= cfg_data[ALW_W-1:0];
				end else begin
					bper_q <= cfg_data;
				end
			end
			if (cmd.do_add) begin
				added_q <= added_q + CW'(1);
				if (cnt_q[0] == '0) begin
					head_q[0] <= added_q[JW-1:0];
				end
				tail_q[0] <= added_q[JW-1:0];
				cnt_q[0]  <= cnt_q[0] + CW'(1);
			end
			if (cmd.unlink) begin
				if (k_q == '0) begin
					head_q[lvi] <= next_q;
				end
				if (tail_q[lvi] == cur_q) begin
					tail_q[lvi] <= prev_q;
				end
				cnt_q[lvi] <= cnt_q[lvi] - CW'(1);
			end
			if (cmd.append) begin
				if (cnt_q[lvn] == '0) begin
					head_q[lvn] <= cur_q;
				end
				tail_q[lvn] <= cur_q;
				cnt_q[lvn]  <= cnt_q[lvn] + CW'(1);
			end
			if (cmd.cnt) begin
				slice_q <= slice_q + SC_W'(1);
			end
			if (cmd.blvl_init) begin
				bany_q   <= 1'b0;
				btotal_q <= '0;
			end
			if (cmd.blvl_take) begin
				if (!bany_q) begin
					bhead_q <= head_q[lvi];
				end
				bany_q   <= 1'b1;
				btail_q  <= tail_q[lvi];
				btotal_q <= btotal_q + cnt_q[lvi];
			end
			if (cmd.bjob_step && st.bjob_end) begin
				cnt_q[lvi] <= '0;
			end
			if (cmd.bst_fin && bany_q) begin
				head_q[0] <= bhead_q;
				tail_q[0] <= btail_q;
				cnt_q[0]  <= btotal_q;
			end
		end
	end

	// The level field holds the level the job ran from; the scan counter is
	// reused by the boost walk, so that level is kept in rlv_q.
	assign event_res     = ev_q;
	assign job_id        = ID_W'(cur_q);
	assign level         = rlv_q;
	assign remaining     = rem_q;
	assign time_in_level = til_q;
	assign boosted       = bst_q;

endmodule

// ===== src/mlfq_time_slice_scheduler_unit.sv =====
// Top level of the multilevel feedback queue time-slice scheduler.
//
// The block keeps up to MAX_JOBS jobs in LEVELS linked queues. Each input
// transfer is either an add (op 0) that appends a job to level 0, or a tick
// (op 1) that runs one time slice of the job picked from the highest
// non-empty level. Every input transfer gives exactly one output transfer.
// A configuration transfer writes allotment_step (index 0) or boost_period
// (index 1); it is taken in any cycle and must only come while idle.
// An add passes through the add and output states. A tick scans the levels for
// the first non-empty one and reports idle if there is none. Otherwise the shared
// serial divider reduces the slice count modulo the level's job count, the queue
// is walked to that position, the job runs and is updated, it is unlinked if it
// completes or moves down and appended to the next level if it moves down, and a
// second remainder pass in the shared divider checks for a boost. A boost walks
// every level and every queued job. Only one item is in flight at a time.
// Reset empties all queues, zeroes the slice and job counters and restores
// allotment_step to 10 and boost_period to 50. When the receiver stalls, the
// result holds on the output and no new input is taken.
module mlfq_time_slice_scheduler_unit
	import mlfq_pkg::*;
#(
	parameter int LEVELS   = LEVELS_DEF,
	parameter int MAX_JOBS = MAX_JOBS_DEF
) (
	input logic clk,
	input logic arst_n,
	mlfq_in_if.sink    in_ch,
	mlfq_out_if.source out_ch,
	mlfq_cfg_if.sink   cfg_ch
);

	status_t st;
	cmd_t    cmd;

	assign cfg_ch.ready = 1'b1;

	mlfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	mlfq_dp #(
		.LEVELS   (LEVELS),
		.MAX_JOBS (MAX_JOBS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_op         (in_ch.op),
		.in_run_time   (in_ch.run_time),
		.cfg_we        (cfg_ch.valid),
		.cfg_index     (cfg_ch.index),
		.cfg_data      (cfg_ch.data),
		.cmd           (cmd),
		.st            (st),
		.event_res     (out_ch.event_res),
		.job_id        (out_ch.job_id),
		.level         (out_ch.level),
		.remaining     (out_ch.remaining),
		.time_in_level (out_ch.time_in_level),
		.boosted       (out_ch.boosted)
	);

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the MLFQ time-slice scheduler.
module tb_top
	import mlfq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NLVL  = 20;
	localparam int NJOBS = 64;

	typedef struct packed {
		event_t            ev;
		logic [ID_W-1:0]   id;
		logic [LVL_W-1:0]  lvl;
		logic [TIME_W-1:0] rem;
		logic [TIME_W-1:0] til;
		logic              bst;
	} sched_res_t;

	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] run_time;
		logic              typed;
		sched_res_t        want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mlfq_in_if  in_ch ();
	mlfq_out_if out_ch ();
	mlfq_cfg_if cfg_ch ();

	mlfq_time_slice_scheduler_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	// Shadow copy of the scheduler state, kept by the predictor.
	logic [ALW_W-1:0]  allot_step;
	logic [TIME_W-1:0] boost_per;
	logic [TIME_W-1:0] job_left [NJOBS];
	logic [TIME_W-1:0] job_slices [NJOBS];
	logic [ID_W-1:0]   job_link [NJOBS];
	logic [ID_W-1:0]   q_head [NLVL];
	logic [ID_W-1:0]   q_tail [NLVL];
	int unsigned       q_count [NLVL];
	logic [SC_W-1:0]   slices_run;
	int unsigned       ids_issued;

	sched_res_t pending_res [$];
	int  mismatches;
	int  n_adds, n_ticks, n_boosts, n_downs, n_done, n_full, n_idle;
	int  idle_mode;      // 0 none, 1 sender gaps, 2 receiver stalls, 3 both
	int  hold_left;      // long receiver hold-off, in cycles

	stim_row_t rows [21];

	// Clock with an 8 ns period.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hard limit on the run time, far above the slowest legal run.
	initial begin
		#40_000_000;
		$display("mlfq_time_slice_scheduler_unit verification failed");
		$finish;
	end

	// Queue append, mirroring how the block links a job onto a level tail.
	function automatic void queue_append(int lv, logic [ID_W-1:0] j);
		if (q_count[lv] == 0)
			q_head[lv] = j;
		else
			job_link[q_tail[lv]] = j;
		q_tail[lv] = j;
		q_count[lv]++;
	endfunction

	// Priority boost: every queue is chained in level order into level 0, and each job's time in level is cleared.
	function automatic void boost_levels();
		logic [ID_W-1:0] first, last, j;
		int unsigned total;
		bit any;
		first = '0;
		last = '0;
		total = 0;
		any = 0;
		for (int lv = 0; lv < NLVL; lv++) begin
			if (q_count[lv] == 0)
				continue;
			if (!any)
				first = q_head[lv];
			else
				job_link[last] = q_head[lv];
			any = 1;
			j = q_head[lv];
			for (int k = 0; k < q_count[lv]; k++) begin
				job_slices[j] = '0;
				if (k + 1 < q_count[lv])
					j = job_link[j];
			end
			last = q_tail[lv];
			total += q_count[lv];
			q_count[lv] = 0;
		end
		if (any) begin
			q_head[0] = first;
			q_tail[0] = last;
			q_count[0] = total;
		end
	endfunction

	// Works out the scheduler's answer to one accepted item and updates the shadow state.
	function automatic sched_res_t schedule_step(logic op, logic [TIME_W-1:0] rt);
		sched_res_t r;
		int lv, pos;
		int unsigned n;
		logic [ID_W-1:0] cur, prv;
		bit done, down;
		r = '{ev: EV_IDLE, id: '0, lvl: '0, rem: '0, til: '0, bst: 1'b0};
		if (op == OP_ADD) begin
			if (ids_issued >= NJOBS) begin
				r.ev = EV_FULL;
			end else begin
				cur = ids_issued[ID_W-1:0];
				job_left[cur] = rt;
				job_slices[cur] = '0;
				queue_append(0, cur);
				ids_issued++;
				r.ev = EV_LOADED;
				r.id = cur;
				r.rem = rt;
			end
			return r;
		end
		for (lv = 0; lv < NLVL; lv++)
			if (q_count[lv] != 0)
				break;
		if (lv == NLVL)
			return r;
		n = q_count[lv];
		pos = slices_run % n;
		cur = q_head[lv];
		prv = cur;
		for (int k = 0; k < pos; k++) begin
			prv = cur;
			cur = job_link[cur];
		end
		if (job_left[cur] != 0)
			job_left[cur]--;
		if (job_slices[cur] != 16'hFFFF)
			job_slices[cur]++;
		r.id = cur;
		r.lvl = lv[LVL_W-1:0];
		r.rem = job_left[cur];
		r.til = job_slices[cur];
		done = (r.rem == 0);
		down = !done && (lv + 1 < NLVL) && (32'(r.til) >= 32'(lv + 1) * 32'(allot_step));
		if (done || down) begin
			if (pos == 0)
				q_head[lv] = job_link[cur];
			else
				job_link[prv] = job_link[cur];
			if (q_tail[lv] == cur)
				q_tail[lv] = prv;
			q_count[lv]--;
		end
		if (done) begin
			r.ev = EV_COMPLETED;
		end else if (down) begin
			job_slices[cur] = '0;
			queue_append(lv + 1, cur);
			r.ev = EV_DOWNGRADE;
		end else begin
			r.ev = EV_RAN;
		end
		slices_run++;
		if (boost_per != 0 && (slices_run % boost_per) == 0) begin
			boost_levels();
			r.bst = 1'b1;
		end
		return r;
	endfunction

	// Offers one item, with random gaps when the sender idles, and records
	// the expected result once the transfer happens. Valid is left high.
	task automatic offer_item(logic op, logic [TIME_W-1:0] rt, bit typed, sched_res_t want);
		sched_res_t got;
		if (idle_mode == 1 || idle_mode == 3) begin
			while ($urandom_range(99) < 59) begin
				in_ch.valid = 1'b0;
				@(negedge clk);
			end
		end
		in_ch.valid = 1'b1;
		in_ch.op = op;
		in_ch.run_time = rt;
		do @(posedge clk); while (!in_ch.ready);
		got = schedule_step(op, rt);
		pending_res.push_back(typed ? want : got);
		if (op == OP_ADD) n_adds++;
		else n_ticks++;
		@(negedge clk);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One register write; only called while the block is idle.
	task automatic write_reg(logic idx, logic [15:0] val);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_ALLOT)
			allot_step = val[ALW_W-1:0];
		else
			boost_per = val;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] pick_run_time();
		int c;
		c = $urandom_range(99);
		if (c < 50) return 16'($urandom_range(30, 1));
		if (c < 80) return 16'($urandom_range(300, 31));
		if (c < 88) return 16'd0;
		return 16'($urandom_range(65535));
	endfunction

	// Random traffic: mostly ticks, with adds spread so ids last a while.
	task automatic random_phase(int items, int mode);
		sched_res_t none;
		bit op;
		none = '0;
		idle_mode = mode;
		for (int i = 0; i < items; i++) begin
			op = ($urandom_range(99) < 14) ? OP_ADD : OP_TICK;
			offer_item(op, pick_run_time(), 1'b0, none);
		end
	endtask

	// Receiver side: ready changes on the falling edge only.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (idle_mode >= 2) begin
			out_ch.ready <= ($urandom_range(99) >= 59);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Result checker: each output transfer is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		sched_res_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: event %0d id %0d",
						out_ch.event_res, out_ch.job_id);
			end else begin
				exp_r = pending_res.pop_front();
				if (out_ch.event_res !== exp_r.ev || out_ch.job_id !== exp_r.id ||
					out_ch.level !== exp_r.lvl || out_ch.remaining !== exp_r.rem ||
					out_ch.time_in_level !== exp_r.til || out_ch.boosted !== exp_r.bst) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected ev %0d id %0d lvl %0d rem %0d til %0d bst %0d",
							exp_r.ev, exp_r.id, exp_r.lvl, exp_r.rem, exp_r.til, exp_r.bst);
						$display("          got      ev %0d id %0d lvl %0d rem %0d til %0d bst %0d",
							out_ch.event_res, out_ch.job_id, out_ch.level,
							out_ch.remaining, out_ch.time_in_level, out_ch.boosted);
					end
				end
				case (exp_r.ev)
					EV_DOWNGRADE: n_downs++;
					EV_COMPLETED: n_done++;
					EV_FULL:      n_full++;
					EV_IDLE:      n_idle++;
					default: ;
				endcase
				if (exp_r.bst)
					n_boosts++;
			end
		end
	end

	// Main sequence: reset, directed table, then random phases under
	// different register settings and idling patterns.
	initial begin
		sched_res_t z;
		z = '0;
		mismatches = 0;
		{n_adds, n_ticks, n_boosts, n_downs, n_done, n_full, n_idle} = '0;
		idle_mode = 0;
		hold_left = 0;
		allot_step = ALLOT_RST;
		boost_per = BOOST_RST;
		slices_run = '0;
		ids_issued = 0;
		for (int i = 0; i < NLVL; i++) begin
			q_count[i] = 0;
			q_head[i] = '0;
			q_tail[i] = '0;
		end
		in_ch.valid = 1'b0;
		in_ch.op = OP_ADD;
		in_ch.run_time = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_ALLOT;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;

		// Directed rows. The first group runs with a zero allotment and a boost
		// after every slice, which covers the empty boost, where the last job
		// completes and the boost finds nothing queued. Ids are never reused, so
		// the expected ids are fixed.
		rows[0]  = '{OP_TICK, 16'd0, 1'b1, '{EV_IDLE, 6'd0, 5'd0, 16'd0, 16'd0, 1'b0}};
		rows[1]  = '{OP_ADD, 16'd1, 1'b1, '{EV_LOADED, 6'd0, 5'd0, 16'd1, 16'd0, 1'b0}};
		rows[2]  = '{OP_TICK, 16'd0, 1'b1, '{EV_COMPLETED, 6'd0, 5'd0, 16'd0, 16'd1, 1'b1}};
		rows[3]  = '{OP_TICK, 16'hFFFF, 1'b1, '{EV_IDLE, 6'd0, 5'd0, 16'd0, 16'd0, 1'b0}};
		rows[4]  = '{OP_ADD, 16'hFFFF, 1'b1, '{EV_LOADED, 6'd1, 5'd0, 16'hFFFF, 16'd0, 1'b0}};
		rows[5]  = '{OP_ADD, 16'd0, 1'b1, '{EV_LOADED, 6'd2, 5'd0, 16'd0, 16'd0, 1'b0}};
		rows[6]  = '{OP_ADD, 16'h5555, 1'b1, '{EV_LOADED, 6'd3, 5'd0, 16'h5555, 16'd0, 1'b0}};
		rows[7]  = '{OP_ADD, 16'hAAAA, 1'b1, '{EV_LOADED, 6'd4, 5'd0, 16'hAAAA, 16'd0, 1'b0}};
		for (int i = 8; i < 13; i++)
			rows[i] = '{OP_TICK, 16'd0, 1'b0, z};
		// Second group: largest allotment and boost period.
		rows[13] = '{OP_ADD, 16'd7, 1'b1, '{EV_LOADED, 6'd5, 5'd0, 16'd7, 16'd0, 1'b0}};
		for (int i = 14; i < 21; i++)
			rows[i] = '{OP_TICK, 16'($urandom_range(65535)), 1'b0, z};

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		write_reg(CFG_ALLOT, 16'd0);
		write_reg(CFG_BOOST, 16'd1);
		for (int i = 0; i < 21; i++) begin
			if (i == 13) begin
				drain();
				write_reg(CFG_ALLOT, 16'd1023);
				write_reg(CFG_BOOST, 16'd65535);
			end
			offer_item(rows[i].op, rows[i].run_time, rows[i].typed, rows[i].want);
		end
		drain();

		// Reset values again, no idling; the receiver is held off for a long
		// stretch so the block fills and stalls its input.
		write_reg(CFG_ALLOT, 16'd10);
		write_reg(CFG_BOOST, 16'd50);
		hold_left = 400;
		random_phase(400, 0);
		drain();

		// Single-slice allotment with a short boost period, sender gaps.
		write_reg(CFG_ALLOT, 16'd1);
		write_reg(CFG_BOOST, 16'd7);
		random_phase(400, 1);
		drain();

		// No boosts and no allotment: jobs sink to the lowest level.
		write_reg(CFG_ALLOT, 16'd0);
		write_reg(CFG_BOOST, 16'd0);
		random_phase(400, 2);
		drain();

		write_reg(CFG_ALLOT, 16'd1023);
		write_reg(CFG_BOOST, 16'd65535);
		random_phase(350, 3);
		drain();

		write_reg(CFG_ALLOT, 16'($urandom_range(6, 2)));
		write_reg(CFG_BOOST, 16'($urandom_range(40, 3)));
		random_phase(450, 3);
		drain();
		repeat (300) @(negedge clk);

		$display("covered %0d adds and %0d ticks under six register settings", n_adds, n_ticks);
		$display("seen %0d completions, %0d downgrades, %0d boosts, %0d idle, %0d table full",
			n_done, n_downs, n_boosts, n_idle, n_full);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("mlfq_time_slice_scheduler_unit verification clean");
		else
			$display("mlfq_time_slice_scheduler_unit verification failed");
		$finish;
	end

endmodule
